FILE: sv/range_gated_scalar_kalman_macros.svh
// Assertion macros shared by the range-gated scalar Kalman filter RTL.
`ifndef RANGE_GATED_SCALAR_KALMAN_MACROS_SVH
`define RANGE_GATED_SCALAR_KALMAN_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RGSK_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rgsk same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RGSK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rgsk next-cycle check failed");

`endif

FILE: sv/rgsk_pkg.sv
// Types, constants and codes of the range-gated scalar Kalman filter.
package rgsk_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int DATA_W     = 32;
	localparam int GAIN_W     = FRAC_BITS + 1;
	localparam int GAIN_OUT_W = 17;
	localparam int DIFF_W     = DATA_W + 1;
	localparam int PROD_W     = GAIN_W + 1 + DIFF_W;
	localparam int CNT_W      = $clog2(FRAC_BITS + 1);
	localparam int CFG_IDX_W  = 3;

	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_BITS;

	localparam logic [DATA_W-1:0] PROCESS_NOISE_RST     = DATA_W'(655);
	localparam logic [DATA_W-1:0] MEASUREMENT_NOISE_RST = DATA_W'(196608);
	localparam logic [DATA_W-1:0] GATE_LOW_RST          = DATA_W'(1966080);
	localparam logic [DATA_W-1:0] GATE_HIGH_RST         = DATA_W'(2949120);
	localparam logic [DATA_W-1:0] VARIANCE_RST          = DATA_W'(1) << FRAC_BITS;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROCESS_NOISE     = 3'd0,
		REG_MEASUREMENT_NOISE = 3'd1,
		REG_GATE_LOW          = 3'd2,
		REG_GATE_HIGH         = 3'd3,
		REG_GATE_ENABLE       = 3'd4
	} rgsk_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_MUL_GAIN,
		ST_MUL_VAR,
		ST_COMMIT,
		ST_FINISH
	} rgsk_state_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic div_step;
		logic mul_gain;
		logic mul_var;
		logic commit;
		logic out_load;
	} rgsk_cmd_t;

	typedef struct packed {
		logic gate_ok;
	} rgsk_stat_t;

endpackage

FILE: sv/rgsk_if.sv
// Sample and result channel interfaces of the range-gated scalar Kalman filter.
interface rgsk_sample_if import rgsk_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] measurement;

	modport source (output valid, output measurement, input ready);
	modport sink (input valid, input measurement, output ready);
endinterface

interface rgsk_result_if import rgsk_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] estimate_out;
	logic                     accepted;
	logic [GAIN_OUT_W-1:0]    gain_out;

	modport source (output valid, output estimate_out, output accepted, output gain_out,
		input ready);
	modport sink (input valid, input estimate_out, input accepted, input gain_out,
		output ready);
endinterface

FILE: sv/range_gated_scalar_kalman.sv
// Top level of the range-gated scalar Kalman filter.
//
//   port      dir   kind          payload
//   sample    in    valid/ready   measurement (s32 Q16.16)
//   result    out   valid/ready   estimate_out (s32), accepted (1), gain_out (u17)
//   cfg_*     in    write only    cfg_index (3), cfg_data (32)
//
// A gated-in sample goes from transfer to result through a prep state, a restoring
// divider for the gain, the gain and variance products on the shared multiplier and a commit.
// A rejected sample goes from prep straight to the result. One sample is in work at a time.
// The result register frees the sample side: a new sample is taken while a result waits.
// Reset loads the register defaults, estimate zero and variance one.
module range_gated_scalar_kalman import rgsk_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,
	rgsk_sample_if.sink          sample,
	rgsk_result_if.source        result
);

	rgsk_cmd_t  cmd;
	rgsk_stat_t stat;

	rgsk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rgsk_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.measurement  (sample.measurement),
		.cmd          (cmd),
		.stat         (stat),
		.estimate_out (result.estimate_out),
		.accepted     (result.accepted),
		.gain_out     (result.gain_out)
	);

endmodule

FILE: sv/rgsk_ctrl.sv
// Sequencer of the filter: gate, divide, multiply, commit and result handoff.
`include "range_gated_scalar_kalman_macros.svh"

module rgsk_ctrl import rgsk_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  rgsk_stat_t stat,
	output rgsk_cmd_t  cmd
);

	rgsk_state_t      state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_PREP;
			end
			ST_PREP: begin
				state_d = stat.gate_ok ? ST_DIV : ST_FINISH;
			end
			ST_DIV: begin
				if (cnt_q == '0) state_d = ST_MUL_GAIN;
			end
			ST_MUL_GAIN: state_d = ST_MUL_VAR;
			ST_MUL_VAR:  state_d = ST_COMMIT;
			ST_COMMIT:   state_d = ST_FINISH;
			ST_FINISH: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		cmd          = '0;
		cmd.load     = in_ready && in_valid;
		cmd.prep     = (state_q == ST_PREP);
		cmd.div_step = (state_q == ST_DIV);
		cmd.mul_gain = (state_q == ST_MUL_GAIN);
		cmd.mul_var  = (state_q == ST_MUL_VAR);
		cmd.commit   = (state_q == ST_COMMIT);
		cmd.out_load = (state_q == ST_FINISH) && (!out_valid_q || out_ready);
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.prep) begin
				cnt_q <= CNT_W'(FRAC_BITS);
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`RGSK_ASSERT_IMPL(a_out_load_free, clk, arst_n, cmd.out_load, !out_valid_q || out_ready)
	`RGSK_ASSERT_NEXT(a_load_to_prep, clk, arst_n, in_valid && in_ready, state_q == ST_PREP)
	`RGSK_ASSERT_IMPL(a_div_count, clk, arst_n, state_q == ST_DIV, cnt_q <= CNT_W'(FRAC_BITS))

endmodule

FILE: sv/rgsk_dp.sv
// Datapath of the filter: registers, gate, serial divider, shared multiplier, state.
`include "range_gated_scalar_kalman_macros.svh"

module rgsk_dp import rgsk_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [DATA_W-1:0]        cfg_data,
	input  logic signed [DATA_W-1:0] measurement,
	input  rgsk_cmd_t                cmd,
	output rgsk_stat_t               stat,
	output logic signed [DATA_W-1:0] estimate_out,
	output logic                     accepted,
	output logic [GAIN_OUT_W-1:0]    gain_out
);

	logic [DATA_W-1:0]        pn_q, mn_q;
	logic signed [DATA_W-1:0] lo_q, hi_q;
	logic                     gate_en_q;
	logic signed [DATA_W-1:0] est_q;
	logic [DATA_W-1:0]        var_q;

	logic signed [DATA_W-1:0] meas_q;
	logic                     ok_q;
	logic [DATA_W-1:0]        p_q;
	logic [DATA_W:0]          d_q;
	logic [DATA_W:0]          rem_q;
	logic                     nbit_q;
	logic [GAIN_W-1:0]        quo_q;
	logic [GAIN_W-1:0]        gain_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [PROD_W-1:0] prod_q;

	logic signed [DATA_W-1:0] est_o_q;
	logic                     acc_o_q;
	logic [GAIN_OUT_W-1:0]    gain_o_q;

	logic                     gate_ok;
	logic [DATA_W:0]          p_sum;
	logic [DATA_W-1:0]        p_sat;
	logic [DATA_W+1:0]        trial;
	logic [DATA_W+1:0]        trial_sub;
	logic                     trial_ge;
	logic [GAIN_W-1:0]        gain_w;
	logic signed [GAIN_W:0]   mul_a;
	logic signed [DIFF_W-1:0] mul_b;
	logic signed [PROD_W-1:0] step_w;

	always_comb begin
		gate_ok   = !gate_en_q || ((measurement > lo_q) && (measurement < hi_q));
		p_sum     = {1'b0, var_q} + {1'b0, pn_q};
		p_sat     = p_sum[DATA_W] ? '1 : p_sum[DATA_W-1:0];
		trial     = {rem_q, nbit_q};
		trial_sub = trial - {1'b0, d_q};
		trial_ge  = (trial >= {1'b0, d_q});
		gain_w    = (d_q == '0) ? '0 : quo_q;
		if (cmd.mul_gain) begin
			mul_a = $signed({1'b0, gain_w});
			mul_b = diff_q;
		end else begin
			mul_a = $signed({1'b0, GAIN_ONE - gain_q});
			mul_b = $signed({1'b0, p_q});
		end
		step_w = prod_q >>> FRAC_BITS;
	end

	assign stat.gate_ok = ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pn_q      <= PROCESS_NOISE_RST;
			mn_q      <= MEASUREMENT_NOISE_RST;
			lo_q      <= GATE_LOW_RST;
			hi_q      <= GATE_HIGH_RST;
			gate_en_q <= 1'b1;
			est_q     <= '0;
			var_q     <= VARIANCE_RST;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PROCESS_NOISE:     pn_q      <= cfg_data;
					REG_MEASUREMENT_NOISE: mn_q      <= cfg_data;
					REG_GATE_LOW:          lo_q      <= cfg_data;
					REG_GATE_HIGH:         hi_q      <= cfg_data;
					REG_GATE_ENABLE:       gate_en_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.mul_var) begin
				est_q <= est_q + step_w[DATA_W-1:0];
			end
			if (cmd.commit) begin
				var_q <= prod_q[FRAC_BITS +: DATA_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			meas_q <= measurement;
			ok_q   <= gate_ok;
			p_q    <= p_sat;
			gain_q <= '0;
		end
		if (cmd.prep) begin
			d_q    <= {1'b0, p_q} + {1'b0, mn_q};
			rem_q  <= {2'b00, p_q[DATA_W-1:1]};
			nbit_q <= p_q[0];
			diff_q <= {meas_q[DATA_W-1], meas_q} - {est_q[DATA_W-1], est_q};
		end
		if (cmd.div_step) begin
			rem_q  <= trial_ge ? trial_sub[DATA_W:0] : trial[DATA_W:0];
			quo_q  <= {quo_q[GAIN_W-2:0], trial_ge};
			nbit_q <= 1'b0;
		end
		if (cmd.mul_gain) begin
			gain_q <= gain_w;
		end
		if (cmd.mul_gain || cmd.mul_var) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.out_load) begin
			est_o_q  <= est_q;
			acc_o_q  <= ok_q;
			gain_o_q <= GAIN_OUT_W'(gain_q);
		end
	end

	assign estimate_out = est_o_q;
	assign accepted     = acc_o_q;
	assign gain_out     = gain_o_q;

	`RGSK_ASSERT_IMPL(a_gain_max, clk, arst_n, cmd.commit, gain_q <= GAIN_ONE)
	`RGSK_ASSERT_NEXT(a_var_shrinks, clk, arst_n, cmd.commit, var_q <= $past(p_q))
	`RGSK_ASSERT_IMPL(a_reject_gain_zero, clk, arst_n, cmd.out_load && !ok_q, gain_q == '0)

endmodule

FILE: verif/tb_range_gated_scalar_kalman.sv
// Self-checking testbench for the range-gated scalar Kalman filter top level.
module tb_range_gated_scalar_kalman;
	import rgsk_pkg::*;

	localparam int REG_COUNT     = 5;
	localparam int MAX_REPORTS   = 10;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int SETTLE_CYCLES = 30;
	localparam int BLOCKS        = 5;
	localparam int BLOCK_ITEMS   = 100;

	localparam logic [DATA_W-1:0] S_MIN = 32'h8000_0000;
	localparam logic [DATA_W-1:0] S_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] U_MAX = 32'hFFFF_FFFF;
	localparam longint LO_LIMIT = -64'sd2147483648;
	localparam longint HI_LIMIT = 64'sd2147483647;

	typedef struct packed {
		logic [DATA_W-1:0]     est;
		logic                  accepted;
		logic [GAIN_OUT_W-1:0] gain;
	} filter_out_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0]    cfg_data;

	rgsk_sample_if sample_ch ();
	rgsk_result_if result_ch ();

	range_gated_scalar_kalman dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_ch.sink),
		.result    (result_ch.source)
	);

	logic [DATA_W-1:0]        process_noise_m = PROCESS_NOISE_RST;
	logic [DATA_W-1:0]        meas_noise_m    = MEASUREMENT_NOISE_RST;
	logic signed [DATA_W-1:0] gate_low_m      = GATE_LOW_RST;
	logic signed [DATA_W-1:0] gate_high_m     = GATE_HIGH_RST;
	logic                     gate_on_m       = 1'b1;
	logic signed [DATA_W-1:0] estimate_m      = '0;
	logic [DATA_W-1:0]        variance_m      = VARIANCE_RST;

	filter_out_t filter_out_q[$];

	int src_idle_pct  = 0;
	int snk_stall_pct = 0;
	int mismatch_count = 0;
	int samples_sent   = 0;
	int gated_in       = 0;
	int zero_div_hits  = 0;
	int results_seen   = 0;

	function automatic logic [DATA_W-1:0] q16(input int v);
		return DATA_W'(v) << FRAC_BITS;
	endfunction

	function automatic filter_out_t kalman_step(input logic signed [DATA_W-1:0] m);
		filter_out_t r;
		longint unsigned gain_one;
		longint unsigned p;
		longint unsigned d;
		longint unsigned k;
		longint diff;
		longint prod;
		logic ok;
		gain_one = 64'd1 << FRAC_BITS;
		k = 0;
		ok = !gate_on_m || (m > gate_low_m && m < gate_high_m);
		if (ok) begin
			gated_in++;
			p = 64'(variance_m) + 64'(process_noise_m);
			if (p > 64'(U_MAX))
				p = 64'(U_MAX);
			d = p + 64'(meas_noise_m);
			if (d != 0)
				k = (p << FRAC_BITS) / d;
			else
				zero_div_hits++;
			if (k > gain_one)
				k = gain_one;
			diff = longint'(m) - longint'(estimate_m);
			prod = longint'(k) * diff;
			estimate_m = DATA_W'(longint'(estimate_m) + (prod >>> FRAC_BITS));
			variance_m = DATA_W'(((gain_one - k) * p) >> FRAC_BITS);
		end
		r.est = estimate_m;
		r.accepted = ok;
		r.gain = GAIN_OUT_W'(k);
		return r;
	endfunction

	task automatic note_mismatch(input string field, input logic [DATA_W-1:0] want,
		input logic [DATA_W-1:0] got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("result %0d: %s expected %h, got %h", results_seen, field, want, got);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		result_ch.ready <= arst_n && ($urandom_range(99) >= snk_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && sample_ch.valid && sample_ch.ready) begin
			filter_out_q.push_back(kalman_step(sample_ch.measurement));
			samples_sent++;
		end
	end

	always @(posedge clk) begin
		filter_out_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			results_seen++;
			if (filter_out_q.size() == 0) begin
				note_mismatch("unexpected result", '0, result_ch.estimate_out);
			end else begin
				want = filter_out_q.pop_front();
				if (result_ch.estimate_out !== want.est)
					note_mismatch("estimate_out", want.est, result_ch.estimate_out);
				if (result_ch.accepted !== want.accepted)
					note_mismatch("accepted", DATA_W'(want.accepted),
						DATA_W'(result_ch.accepted));
				if (result_ch.gain_out !== want.gain)
					note_mismatch("gain_out", DATA_W'(want.gain), DATA_W'(result_ch.gain_out));
			end
		end
	end

	// hold valid across back-to-back transfers; drop it only for a gap
	task automatic send_sample(input logic [DATA_W-1:0] m);
		if ($urandom_range(99) < src_idle_pct) begin
			sample_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.measurement <= m;
		do @(posedge clk); while (!sample_ch.ready);
	endtask

	task automatic quiesce();
		int waited;
		waited = 0;
		sample_ch.valid <= 1'b0;
		do begin
			@(posedge clk);
			waited++;
		end while (filter_out_q.size() != 0 && waited < DRAIN_LIMIT);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_PROCESS_NOISE:     process_noise_m = data;
			REG_MEASUREMENT_NOISE: meas_noise_m = data;
			REG_GATE_LOW:          gate_low_m = data;
			REG_GATE_HIGH:         gate_high_m = data;
			REG_GATE_ENABLE:       gate_on_m = data[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] pick_noise();
		case ($urandom_range(7))
			0: return '0;
			1: return U_MAX;
			2: return $urandom;
			3: return $urandom_range(15);
			default: return $urandom_range(1 << 20);
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_measurement();
		longint span;
		longint unsigned r;
		span = longint'(gate_high_m) - longint'(gate_low_m) - 1;
		r = {$urandom, $urandom};
		case ($urandom_range(19))
			0, 1, 2: return $urandom;
			3: return $urandom_range(1) ? S_MIN : S_MAX;
			4: return gate_low_m + DATA_W'($urandom_range(1));
			5: return gate_high_m - DATA_W'($urandom_range(1));
			default: begin
				if (span > 0)
					return DATA_W'(longint'(gate_low_m) + 1 + longint'(r % 64'(span)));
				return $urandom;
			end
		endcase
	endfunction

	task automatic shuffle_setup();
		longint lo;
		longint hi;
		longint c;
		longint w;
		case ($urandom_range(9))
			0: begin
				lo = LO_LIMIT;
				hi = HI_LIMIT;
			end
			1: begin
				lo = longint'($signed($urandom));
				hi = lo;
			end
			2: begin
				lo = longint'($signed($urandom));
				hi = longint'($signed($urandom));
			end
			default: begin
				c = longint'($signed($urandom));
				w = longint'($urandom >> $urandom_range(31, 1));
				lo = (c - w < LO_LIMIT) ? LO_LIMIT : c - w;
				hi = (c + w > HI_LIMIT) ? HI_LIMIT : c + w;
			end
		endcase
		write_reg(REG_PROCESS_NOISE, pick_noise());
		write_reg(REG_MEASUREMENT_NOISE, pick_noise());
		write_reg(REG_GATE_LOW, DATA_W'(lo));
		write_reg(REG_GATE_HIGH, DATA_W'(hi));
		write_reg(REG_GATE_ENABLE, ($urandom & ~32'd1) | 32'($urandom_range(4) != 0));
		if ($urandom_range(3) == 0)
			write_reg(CFG_IDX_W'(REG_COUNT + $urandom_range((1 << CFG_IDX_W) - 1 - REG_COUNT)),
				$urandom);
	endtask

	task automatic test_reset_gate();
		send_sample(q16(36));
		send_sample(q16(30));
		send_sample(q16(30) + 1);
		send_sample(q16(45));
		send_sample(q16(45) - 1);
		send_sample(S_MIN);
		send_sample(S_MAX);
		send_sample(q16(40));
	endtask

	task automatic test_zero_divisor();
		quiesce();
		write_reg(REG_PROCESS_NOISE, '0);
		write_reg(REG_MEASUREMENT_NOISE, '0);
		write_reg(REG_GATE_ENABLE, 32'hFFFF_FFFE);
		send_sample(q16(40));
		send_sample(-q16(5));
		send_sample(S_MAX);
	endtask

	task automatic test_noise_extremes();
		quiesce();
		write_reg(REG_PROCESS_NOISE, U_MAX);
		write_reg(REG_MEASUREMENT_NOISE, U_MAX);
		send_sample(S_MIN);
		send_sample(S_MAX);
		quiesce();
		write_reg(REG_MEASUREMENT_NOISE, '0);
		send_sample(S_MIN);
	endtask

	task automatic test_empty_gate();
		quiesce();
		write_reg(REG_GATE_ENABLE, 32'd3);
		write_reg(REG_GATE_LOW, '0);
		write_reg(REG_GATE_HIGH, '0);
		send_sample('0);
		send_sample(32'd1);
		send_sample(U_MAX);
		quiesce();
		write_reg(REG_GATE_LOW, S_MAX);
		write_reg(REG_GATE_HIGH, S_MIN);
		send_sample('0);
	endtask

	task automatic test_full_gate();
		quiesce();
		write_reg(REG_PROCESS_NOISE, PROCESS_NOISE_RST);
		write_reg(REG_MEASUREMENT_NOISE, MEASUREMENT_NOISE_RST);
		write_reg(REG_GATE_LOW, S_MIN);
		write_reg(REG_GATE_HIGH, S_MAX);
		send_sample(S_MIN);
		send_sample(S_MIN + 1);
		send_sample(S_MAX - 1);
		send_sample(S_MAX);
	endtask

	task automatic test_unmapped_index();
		quiesce();
		for (int idx = REG_COUNT; idx < (1 << CFG_IDX_W); idx++)
			write_reg(CFG_IDX_W'(idx), U_MAX);
		send_sample(q16(3));
		send_sample(-q16(7));
	endtask

	task automatic test_random_traffic(input int src_pct, input int snk_pct);
		src_idle_pct = src_pct;
		snk_stall_pct = snk_pct;
		for (int blk = 0; blk < BLOCKS; blk++) begin
			quiesce();
			shuffle_setup();
			for (int i = 0; i < BLOCK_ITEMS; i++)
				send_sample(pick_measurement());
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		sample_ch.valid <= 1'b0;
		sample_ch.measurement <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_gate();
		test_zero_divisor();
		test_noise_extremes();
		test_empty_gate();
		test_full_gate();
		test_unmapped_index();
		test_random_traffic(0, 0);
		test_random_traffic(75, 0);
		test_random_traffic(0, 75);
		test_random_traffic(15, 15);

		quiesce();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (filter_out_q.size() != 0) begin
			$display("%0d results never arrived", filter_out_q.size());
			mismatch_count += filter_out_q.size();
		end
		$display("Sent %0d samples through four traffic phases: %0d passed the gate,",
			samples_sent, gated_in);
		$display("%0d zero divisors; checked %0d results, %0d field errors",
			zero_div_hits, results_seen, mismatch_count);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
